@@ sv/psmc_pkg.sv @@
package psmc_pkg;

  localparam int MaxVertices = 64;
  localparam int CoordW      = 24;

  localparam int AddrW  = (MaxVertices > 1) ? $clog2(MaxVertices) : 1;
  localparam int CountW = $clog2(MaxVertices + 1);
  localparam int SumW   = CoordW + AddrW;
  localparam int CentW  = CoordW + 1;
  localparam int RemW   = CountW + 1;
  localparam int StepW  = $clog2(SumW + 1);

  localparam int VtxW     = 3 * CoordW;
  localparam int InDataW  = ((VtxW + 7) / 8) * 8;
  localparam int OutW     = 3 * CentW;
  localparam int OutDataW = ((OutW + 7) / 8) * 8;

  typedef struct packed {
    logic signed [CoordW-1:0] z;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] x;
  } vertex_t;

  typedef struct packed {
    logic                     start;
    logic signed [SumW-1:0]   dividend;
    logic        [CountW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [CentW-1:0] quotient;
  } div_rsp_t;

endpackage

@@ sv/psmc_store.sv @@
module psmc_store (
  input  logic                   clk_i,
  input  logic                   wr_en_i,
  input  logic [psmc_pkg::AddrW-1:0] wr_addr_i,
  input  psmc_pkg::vertex_t      wr_data_i,
  input  logic                   rd_en_i,
  input  logic [psmc_pkg::AddrW-1:0] rd_addr_i,
  output psmc_pkg::vertex_t      rd_data_o
);
  import psmc_pkg::*;

  vertex_t mem_q [MaxVertices];
  vertex_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ sv/psmc_div.sv @@
module psmc_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  psmc_pkg::div_req_t req_i,
  output psmc_pkg::div_rsp_t rsp_o
);
  import psmc_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic              neg_q, neg_d;
  logic [StepW-1:0]  step_q, step_d;
  logic [RemW-1:0]   rem_q, rem_d;
  logic [SumW-1:0]   quo_q, quo_d;
  logic [CountW-1:0] dvs_q, dvs_d;
  logic [RemW-1:0]   trial;
  logic              ge;
  logic [SumW-1:0]   q_full;

  // restoring divide, one quotient bit per cycle on the magnitude
  assign trial = {rem_q[RemW-2:0], quo_q[SumW-1]};
  assign ge    = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    neg_d  = neg_q;
    step_d = step_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      neg_d  = req_i.dividend[SumW-1];
      step_d = '0;
      rem_d  = '0;
      quo_d  = req_i.dividend[SumW-1] ? SumW'(-req_i.dividend) : SumW'(req_i.dividend);
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d  = ge ? (trial - {1'b0, dvs_q}) : trial;
      quo_d  = {quo_q[SumW-2:0], ge};
      step_d = step_q + StepW'(1);
      if (step_q == StepW'(SumW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      neg_q  <= 1'b0;
      step_q <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      dvs_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      neg_q  <= neg_d;
      step_q <= step_d;
      rem_q  <= rem_d;
      quo_q  <= quo_d;
      dvs_q  <= dvs_d;
    end
  end

  assign q_full         = neg_q ? (~quo_q + SumW'(1)) : quo_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = signed'(q_full[CentW-1:0]);

endmodule

@@ sv/point_set_mean_centering.sv @@
// channel   dir  tdata (low bit up)                          tlast          tuser
// s_axis    in   vertex_x, vertex_y, vertex_z                last_vertex    -
// m_axis    out  centered_x, centered_y, centered_z, zeros   final_result   overflow_flag
//
// loading takes one vertex word per cycle, limited by the store write port
// after the last vertex, the shared divider computes the x, y and z centroids in turn
// emission gives one word per cycle from the store read port unless stalled, then loading resumes
// async active-low reset clears sums, count, flags and the sequencer; store is not cleared
// a stalled output holds the current word while the next store read waits
module point_set_mean_centering (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [psmc_pkg::InDataW-1:0]    s_axis_tdata,  // vertex_x, vertex_y, vertex_z
  input  logic                            s_axis_tlast,  // last_vertex
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [psmc_pkg::OutDataW-1:0]   m_axis_tdata,  // centered_x, centered_y, centered_z
  output logic                            m_axis_tlast,  // final_result
  output logic                            m_axis_tuser   // overflow_flag
);
  import psmc_pkg::*;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_EMIT
  } state_e;

  state_e                  state_q, state_d;
  logic [1:0]              axis_q, axis_d;
  logic signed [SumW-1:0]  sum_q [3];
  logic signed [SumW-1:0]  sum_d [3];
  logic signed [CentW-1:0] cent_q [3];
  logic signed [CentW-1:0] cent_d [3];
  logic [CountW-1:0]       cnt_q, cnt_d;
  logic                    dropped_q, dropped_d;
  logic [CountW-1:0]       issue_q, issue_d;
  logic                    rd_pend_q, rd_pend_d;
  logic                    pend_last_q, pend_last_d;
  logic                    out_valid_q, out_valid_d;
  logic                    out_last_q, out_last_d;
  logic                    out_drop_q, out_drop_d;
  logic [OutW-1:0]         out_data_q, out_data_d;

  vertex_t   in_vtx;
  vertex_t   rd_vtx;
  logic      in_fire;
  logic      has_room;
  logic      out_load;
  logic      rd_en;
  div_req_t  div_req;
  div_rsp_t  div_rsp;
  logic signed [CentW-1:0] dx, dy, dz;

  assign in_vtx        = vertex_t'(s_axis_tdata[VtxW-1:0]);
  assign s_axis_tready = (state_q == ST_LOAD);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign has_room      = cnt_q < CountW'(MaxVertices);
  assign out_load      = rd_pend_q && (!out_valid_q || m_axis_tready);
  assign rd_en         = (state_q == ST_EMIT) && (issue_q < cnt_q) && (!rd_pend_q || out_load);

  assign div_req.start    = (state_q == ST_DIV_START);
  assign div_req.dividend = sum_q[axis_q];
  assign div_req.divisor  = cnt_q;

  psmc_store u_store (
    .clk_i     (clk_i),
    .wr_en_i   (in_fire && has_room),
    .wr_addr_i (cnt_q[AddrW-1:0]),
    .wr_data_i (in_vtx),
    .rd_en_i   (rd_en),
    .rd_addr_i (issue_q[AddrW-1:0]),
    .rd_data_o (rd_vtx)
  );

  psmc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign dx = {rd_vtx.x[CoordW-1], rd_vtx.x} - cent_q[0];
  assign dy = {rd_vtx.y[CoordW-1], rd_vtx.y} - cent_q[1];
  assign dz = {rd_vtx.z[CoordW-1], rd_vtx.z} - cent_q[2];

  always_comb begin
    state_d     = state_q;
    axis_d      = axis_q;
    sum_d       = sum_q;
    cent_d      = cent_q;
    cnt_d       = cnt_q;
    dropped_d   = dropped_q;
    issue_d     = issue_q;
    rd_pend_d   = rd_pend_q;
    pend_last_d = pend_last_q;
    out_valid_d = out_valid_q;
    out_last_d  = out_last_q;
    out_drop_d  = out_drop_q;
    out_data_d  = out_data_q;

    case (state_q)
      ST_LOAD: begin
        if (in_fire) begin
          if (has_room) begin
            sum_d[0] = sum_q[0] + SumW'(in_vtx.x);
            sum_d[1] = sum_q[1] + SumW'(in_vtx.y);
            sum_d[2] = sum_q[2] + SumW'(in_vtx.z);
            cnt_d    = cnt_q + CountW'(1);
          end else begin
            dropped_d = 1'b1;
          end
          if (s_axis_tlast) begin
            state_d = ST_DIV_START;
            axis_d  = '0;
          end
        end
      end
      ST_DIV_START: begin
        state_d = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          cent_d[axis_q] = div_rsp.quotient;
          if (axis_q == 2'd2) begin
            state_d = ST_EMIT;
            issue_d = '0;
          end else begin
            axis_d  = axis_q + 2'd1;
            state_d = ST_DIV_START;
          end
        end
      end
      ST_EMIT: begin
        if (rd_en) begin
          issue_d     = issue_q + CountW'(1);
          pend_last_d = (issue_q == cnt_q - CountW'(1));
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase

    if (rd_en) begin
      rd_pend_d = 1'b1;
    end else if (out_load) begin
      rd_pend_d = 1'b0;
    end

    if (out_load) begin
      out_valid_d = 1'b1;
      out_data_d  = {dz, dy, dx};
      out_last_d  = pend_last_q;
      out_drop_d  = dropped_q;
      if (pend_last_q) begin
        sum_d[0]  = '0;
        sum_d[1]  = '0;
        sum_d[2]  = '0;
        cnt_d     = '0;
        dropped_d = 1'b0;
        state_d   = ST_LOAD;
      end
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      axis_q      <= '0;
      sum_q       <= '{default: '0};
      cent_q      <= '{default: '0};
      cnt_q       <= '0;
      dropped_q   <= 1'b0;
      issue_q     <= '0;
      rd_pend_q   <= 1'b0;
      pend_last_q <= 1'b0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
      out_drop_q  <= 1'b0;
      out_data_q  <= '0;
    end else begin
      state_q     <= state_d;
      axis_q      <= axis_d;
      sum_q       <= sum_d;
      cent_q      <= cent_d;
      cnt_q       <= cnt_d;
      dropped_q   <= dropped_d;
      issue_q     <= issue_d;
      rd_pend_q   <= rd_pend_d;
      pend_last_q <= pend_last_d;
      out_valid_q <= out_valid_d;
      out_last_q  <= out_last_d;
      out_drop_q  <= out_drop_d;
      out_data_q  <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutDataW'(out_data_q);
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_drop_q;

`ifndef SYNTHESIS
  // the final word of a set leaves the set state cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && pend_last_q) |=> (cnt_q == '0 && !dropped_q && state_q == ST_LOAD))
    else $error("set state not cleared after final word");

  // reads never run past the stored vertices
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (issue_q <= cnt_q))
    else $error("store read index beyond vertex count");

  // the divider only answers while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == ST_DIV_WAIT))
    else $error("divider result outside wait state");

  // the divider is never started on an empty set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> (cnt_q != '0))
    else $error("centroid divide with zero count");
`endif

endmodule

@@ tb/sv/point_set_mean_centering_tb.sv @@
`timescale 1ns / 100ps

module point_set_mean_centering_tb;
  import psmc_pkg::*;

  localparam int StallLimit = 4000;
  localparam int DrainCycles = 200;
  localparam int RandItems = 250;

  typedef struct {
    vertex_t v;
    logic    last;
    bit      drain;
  } vertex_word_t;

  typedef struct {
    logic signed [CentW-1:0] x;
    logic signed [CentW-1:0] y;
    logic signed [CentW-1:0] z;
    logic                    last;
    logic                    ovf;
  } centered_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [InDataW-1:0]    s_axis_tdata;
  logic                  s_axis_tlast;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OutDataW-1:0]   m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  m_axis_tuser;

  vertex_word_t vertex_q[$];
  centered_t    centered_q[$];

  vertex_t pts[MaxVertices];
  longint  sum_x, sum_y, sum_z;
  int      set_count;
  bit      set_dropped;

  int  total_items;
  int  words_in;
  int  errors;
  int  stall_cycles;
  bit  in_fire;

  point_set_mean_centering dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  task automatic report_mismatch(input string what, input longint got, input longint exp);
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, exp);
    errors++;
  endtask

  function automatic void add_vertex(input logic [CoordW-1:0] x, input logic [CoordW-1:0] y,
                                     input logic [CoordW-1:0] z, input logic last,
                                     input bit drain = 1'b0);
    vertex_word_t w;
    w.v.x = x;
    w.v.y = y;
    w.v.z = z;
    w.last = last;
    w.drain = drain;
    vertex_q.push_back(w);
  endfunction

  function automatic logic [CoordW-1:0] rand_coord();
    case ($urandom_range(7))
      0: return {1'b0, {(CoordW-1){1'b1}}};
      1: return {1'b1, {(CoordW-1){1'b0}}};
      2: return CoordW'($urandom_range(16) - 8);
      default: return CoordW'($urandom);
    endcase
  endfunction

  // store, sum, and on the last vertex expand the set into centered words
  function automatic void accumulate_vertex(input vertex_t v, input logic last);
    longint    cx, cy, cz, dx, dy, dz;
    centered_t r;
    if (set_count < MaxVertices) begin
      pts[set_count] = v;
      sum_x += longint'(v.x);
      sum_y += longint'(v.y);
      sum_z += longint'(v.z);
      set_count++;
    end else begin
      set_dropped = 1'b1;
    end
    if (!last) return;
    if (set_count != 0) begin
      cx = sum_x / set_count;
      cy = sum_y / set_count;
      cz = sum_z / set_count;
      for (int i = 0; i < set_count; i++) begin
        dx = longint'(pts[i].x) - cx;
        dy = longint'(pts[i].y) - cy;
        dz = longint'(pts[i].z) - cz;
        r.x = dx[CentW-1:0];
        r.y = dy[CentW-1:0];
        r.z = dz[CentW-1:0];
        r.last = (i + 1 == set_count);
        r.ovf = set_dropped;
        centered_q.push_back(r);
      end
    end
    sum_x = 0;
    sum_y = 0;
    sum_z = 0;
    set_count = 0;
    set_dropped = 1'b0;
  endfunction

  // monitor: predict on accepted vertex words, check accepted centered words
  always @(posedge clk_i or negedge rst_ni) begin
    centered_t got, exp;
    if (!rst_ni) begin
      in_fire <= 1'b0;
      stall_cycles <= 0;
    end else begin
      in_fire <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        words_in++;
        accumulate_vertex(vertex_t'(s_axis_tdata[VtxW-1:0]), s_axis_tlast);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.x = m_axis_tdata[CentW-1:0];
        got.y = m_axis_tdata[2*CentW-1:CentW];
        got.z = m_axis_tdata[3*CentW-1:2*CentW];
        got.last = m_axis_tlast;
        got.ovf = m_axis_tuser;
        if (centered_q.size() == 0) begin
          $display("%0t unexpected word x=%0d y=%0d z=%0d", $realtime, got.x, got.y, got.z);
          errors++;
        end else begin
          exp = centered_q.pop_front();
          if (got.x !== exp.x) report_mismatch("centered_x", got.x, exp.x);
          if (got.y !== exp.y) report_mismatch("centered_y", got.y, exp.y);
          if (got.z !== exp.z) report_mismatch("centered_z", got.z, exp.z);
          if (got.last !== exp.last) report_mismatch("final_result", got.last, exp.last);
          if (got.ovf !== exp.ovf) report_mismatch("overflow_flag", got.ovf, exp.ovf);
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // driver and receiver, idling rates follow the progress of the stimulus
  always @(negedge clk_i) begin
    int           send_idle, recv_idle;
    vertex_word_t w;
    if (words_in < total_items / 3) begin
      send_idle = 9;
      recv_idle = 58;
    end else if (words_in < 2 * total_items / 3) begin
      send_idle = 58;
      recv_idle = 9;
    end else begin
      send_idle = 0;
      recv_idle = 0;
    end
    m_axis_tready <= ($urandom_range(99) >= recv_idle);
    if (rst_ni && (!s_axis_tvalid || in_fire)) begin
      if (vertex_q.size() != 0 && $urandom_range(99) >= send_idle &&
          !(vertex_q[0].drain && centered_q.size() != 0)) begin
        w = vertex_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= InDataW'(w.v);
        s_axis_tlast <= w.last;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  initial begin
    int n_rand, set_idx, size;
    logic [CoordW-1:0] pmax, pmin;
    pmax = {1'b0, {(CoordW-1){1'b1}}};
    pmin = {1'b1, {(CoordW-1){1'b0}}};
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    m_axis_tready = 1'b0;
    words_in = 0;
    errors = 0;
    sum_x = 0;
    sum_y = 0;
    sum_z = 0;
    set_count = 0;
    set_dropped = 1'b0;

    // single vertex sets at both extremes
    add_vertex(pmax, pmax, pmax, 1'b1);
    add_vertex(pmin, pmin, pmin, 1'b1);
    // negative odd sum, centroid rounds toward zero
    add_vertex(pmax, pmin, pmax, 1'b0);
    add_vertex(pmin, pmax, pmin, 1'b1);
    add_vertex(CoordW'(-1), CoordW'(1), pmin, 1'b0);
    add_vertex(CoordW'(-1), CoordW'(1), pmin, 1'b0);
    add_vertex('0, '0, pmin, 1'b1);
    for (int i = 0; i < 4; i++) add_vertex(pmax, pmin, pmax, i == 3);
    for (int i = 0; i < 4; i++) add_vertex(pmin, pmax, pmin, i == 3);
    add_vertex(CoordW'(24'h555555), CoordW'(24'haaaaaa), '0, 1'b0);
    add_vertex(CoordW'(24'haaaaaa), '0, CoordW'(24'h555555), 1'b0);
    add_vertex('0, CoordW'(24'h555555), CoordW'(24'haaaaaa), 1'b0);
    add_vertex(pmax, pmax, CoordW'(-7), 1'b1);

    // random sets, mostly short, one full store and one that overflows on its last two words
    n_rand = 0;
    set_idx = 0;
    while (n_rand < RandItems) begin
      if (set_idx == 3) size = MaxVertices;
      else if (set_idx == 9) size = MaxVertices + 2;
      else if ($urandom_range(9) == 0) size = $urandom_range(30, 9);
      else size = $urandom_range(8, 1);
      for (int i = 0; i < size; i++) begin
        add_vertex(rand_coord(), rand_coord(), rand_coord(), i == size - 1,
                   i == 0 && (set_idx == 0 || $urandom_range(7) == 0));
      end
      n_rand += size;
      set_idx++;
    end
    total_items = vertex_q.size();

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    wait (words_in == total_items);
    wait (centered_q.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
